[hdl/sdtt_pkg.sv]
// Shared types and constants for the sleep deadline timer table.
`timescale 1ns / 1ps
`default_nettype none
package sdtt_pkg;

  localparam int CMD_W  = 2;
  localparam int ID_W   = 16;
  localparam int DL_W   = 64;
  localparam int STAT_W = 3;
  localparam int INC_W  = 32;

  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

  localparam logic [STAT_W-1:0] STAT_OK         = 3'd0;
  localparam logic [STAT_W-1:0] STAT_WOKEN      = 3'd1;
  localparam logic [STAT_W-1:0] STAT_NONE_WOKEN = 3'd2;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND  = 3'd3;
  localparam logic [STAT_W-1:0] STAT_FULL       = 3'd4;

  localparam logic [INC_W-1:0] TICK_INC_RESET = 32'd1000000;

  // Slot store control from the sequencer.
  typedef struct packed {
    logic write;  // write id and deadline, mark slot valid
    logic clear;  // mark slot free
  } store_ctl_t;

endpackage
`default_nettype wire

[hdl/sdtt_cmd_if.sv]
// Command channel: valid/ready handshake with the command word.
`timescale 1ns / 1ps
`default_nettype none
interface sdtt_cmd_if;
  import sdtt_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [ID_W-1:0]   sleeper_id;
  logic [DL_W-1:0]   deadline;

  modport source (output valid, command, sleeper_id, deadline, input ready);
  modport sink   (input valid, command, sleeper_id, deadline, output ready);
endinterface
`default_nettype wire

[hdl/sdtt_res_if.sv]
// Result channel: valid/ready handshake with the result word.
`timescale 1ns / 1ps
`default_nettype none
interface sdtt_res_if;
  import sdtt_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [ID_W-1:0]   woken_id;
  logic              last;

  modport source (output valid, status, woken_id, last, input ready);
  modport sink   (input valid, status, woken_id, last, output ready);
endinterface
`default_nettype wire

[hdl/sdtt_slot_store.sv]
// Slot table: id and deadline memory with registered read, plus valid flags.
`timescale 1ns / 1ps
`default_nettype none
module sdtt_slot_store #(
  parameter int SLOTS   = 16,
  parameter int ID_BITS = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  input  wire logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] rd_addr,
  input  wire logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] wr_addr,
  input  wire sdtt_pkg::store_ctl_t                      ctl,
  input  wire logic [ID_BITS-1:0]                        wr_id,
  input  wire logic [sdtt_pkg::DL_W-1:0]                 wr_deadline,
  output      logic [SLOTS-1:0]                          valid_vec,
  output      logic [ID_BITS-1:0]                        rd_id,
  output      logic [sdtt_pkg::DL_W-1:0]                 rd_deadline
);
  import sdtt_pkg::*;

  logic [ID_BITS-1:0] mem_id [SLOTS];
  logic [DL_W-1:0]    mem_dl [SLOTS];

  always_ff @(posedge clk) begin
    if (ctl.write) begin
      mem_id[wr_addr] <= wr_id;
      mem_dl[wr_addr] <= wr_deadline;
    end
    rd_id       <= mem_id[rd_addr];
    rd_deadline <= mem_dl[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_vec <= '0;
    end else if (ctl.write) begin
      valid_vec[wr_addr] <= 1'b1;
    end else if (ctl.clear) begin
      valid_vec[wr_addr] <= 1'b0;
    end
  end

endmodule
`default_nettype wire

[hdl/sdtt_scan_ctrl.sv]
// Sequencer: scans one slot per cycle unless stalled; shared id/dl compare.
`timescale 1ns / 1ps
`default_nettype none
module sdtt_scan_ctrl #(
  parameter int SLOTS   = 16,
  parameter int ID_BITS = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  input  wire logic                                      cfg_we,
  input  wire logic [sdtt_pkg::INC_W-1:0]                cfg_wdata,
  sdtt_cmd_if.sink                                       cmd,
  sdtt_res_if.source                                     res,
  output      logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] rd_addr,
  output      logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] wr_addr,
  output      sdtt_pkg::store_ctl_t                      ctl,
  output      logic [ID_BITS-1:0]                        wr_id,
  output      logic [sdtt_pkg::DL_W-1:0]                 wr_deadline,
  input  wire logic [SLOTS-1:0]                          valid_vec,
  input  wire logic [ID_BITS-1:0]                        rd_id,
  input  wire logic [sdtt_pkg::DL_W-1:0]                 rd_deadline
);
  import sdtt_pkg::*;

  localparam int IDX_W = SLOTS > 1 ? $clog2(SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]         state, state_next;
  logic [CMD_W-1:0]   cmd_r;
  logic [ID_BITS-1:0] id_r;
  logic [DL_W-1:0]    dl_r;
  logic [DL_W-1:0]    cur_time;
  logic [INC_W-1:0]   tick_inc;
  logic [IDX_W-1:0]   idx, idx_next;
  logic               hit_found, hit_found_next;
  logic [IDX_W-1:0]   hit_slot, hit_slot_next;
  logic               free_found, free_found_next;
  logic [IDX_W-1:0]   free_slot, free_slot_next;
  logic               pend_vld, pend_vld_next;
  logic [ID_BITS-1:0] pend_id, pend_id_next;
  logic               out_vld;
  logic [STAT_W-1:0]  out_stat;
  logic [ID_W-1:0]    out_id;
  logic               out_last;

  logic               accept, out_free, slot_vld, id_eq, due, wake, step;
  logic               load_out;
  logic [STAT_W-1:0]  lo_stat;
  logic [ID_W-1:0]    lo_id;
  logic               lo_last;

  assign cmd.ready   = (state == S_IDLE);
  assign accept      = cmd.valid && cmd.ready;
  assign out_free    = !out_vld || res.ready;
  assign res.valid   = out_vld;
  assign res.status  = out_stat;
  assign res.woken_id = out_id;
  assign res.last    = out_last;

  // Shared compare unit on the slot under the scan index.
  assign slot_vld = valid_vec[idx];
  assign id_eq    = (rd_id == id_r);
  assign due      = (rd_deadline <= cur_time);
  assign wake     = slot_vld && due;

  assign rd_addr     = idx_next;
  assign wr_id       = id_r;
  assign wr_deadline = dl_r;

  always_comb begin
    state_next      = state;
    idx_next        = idx;
    hit_found_next  = hit_found;
    hit_slot_next   = hit_slot;
    free_found_next = free_found;
    free_slot_next  = free_slot;
    pend_vld_next   = pend_vld;
    pend_id_next    = pend_id;
    ctl             = '0;
    wr_addr         = idx;
    load_out        = 1'b0;
    lo_stat         = STAT_OK;
    lo_id           = ID_W'(id_r);
    lo_last         = 1'b1;
    step            = 1'b0;

    case (state)
      S_IDLE: begin
        idx_next = '0;
        if (accept && cmd.command != CMD_NONE) begin
          state_next      = S_SCAN;
          hit_found_next  = 1'b0;
          free_found_next = 1'b0;
          pend_vld_next   = 1'b0;
        end
      end

      S_SCAN: begin
        step = 1'b1;
        if (cmd_r == CMD_TICK) begin
          if (wake && pend_vld && !out_free) begin
            // hold until the previous wake word can go out
            step = 1'b0;
          end else if (wake) begin
            ctl.clear     = 1'b1;
            pend_id_next  = rd_id;
            pend_vld_next = 1'b1;
            if (pend_vld) begin
              load_out = 1'b1;
              lo_stat  = STAT_WOKEN;
              lo_id    = ID_W'(pend_id);
              lo_last  = 1'b0;
            end
          end
        end else begin
          if (slot_vld && id_eq && !hit_found) begin
            hit_found_next = 1'b1;
            hit_slot_next  = idx;
          end
          if (!slot_vld && !free_found) begin
            free_found_next = 1'b1;
            free_slot_next  = idx;
          end
        end
        if (step) begin
          if (idx == LAST_IDX) begin
            state_next = S_DONE;
            idx_next   = '0;
          end else begin
            idx_next = idx + IDX_W'(1);
          end
        end
      end

      S_DONE: begin
        idx_next = '0;
        if (out_free) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
          case (cmd_r)
            CMD_ADD: begin
              if (hit_found) begin
                ctl.write = 1'b1;
                wr_addr   = hit_slot;
              end else if (free_found) begin
                ctl.write = 1'b1;
                wr_addr   = free_slot;
              end else begin
                lo_stat = STAT_FULL;
              end
            end
            CMD_REMOVE: begin
              if (hit_found) begin
                ctl.clear = 1'b1;
                wr_addr   = hit_slot;
              end else begin
                lo_stat = STAT_NOT_FOUND;
              end
            end
            CMD_TICK: begin
              if (pend_vld) begin
                lo_stat = STAT_WOKEN;
                lo_id   = ID_W'(pend_id);
              end else begin
                lo_stat = STAT_NONE_WOKEN;
                lo_id   = '0;
              end
            end
            default: begin
              lo_stat = STAT_OK;
            end
          endcase
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      idx        <= '0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
      pend_vld   <= 1'b0;
      out_vld    <= 1'b0;
      cur_time   <= '0;
      tick_inc   <= TICK_INC_RESET;
    end else begin
      state      <= state_next;
      idx        <= idx_next;
      hit_found  <= hit_found_next;
      free_found <= free_found_next;
      pend_vld   <= pend_vld_next;
      if (cfg_we) begin
        tick_inc <= cfg_wdata;
      end
      if (accept && cmd.command == CMD_TICK) begin
        cur_time <= cur_time + DL_W'(tick_inc);
      end
      if (load_out) begin
        out_vld <= 1'b1;
      end else if (res.ready) begin
        out_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    hit_slot  <= hit_slot_next;
    free_slot <= free_slot_next;
    pend_id   <= pend_id_next;
    if (accept) begin
      cmd_r <= cmd.command;
      id_r  <= ID_BITS'(cmd.sleeper_id);
      dl_r  <= cmd.deadline;
    end
    if (load_out) begin
      out_stat <= lo_stat;
      out_id   <= lo_id;
      out_last <= lo_last;
    end
  end

endmodule
`default_nettype wire

[hdl/sleep_deadline_timer_table.sv]
// Top level of the sleep deadline timer table.
`timescale 1ns / 1ps
`default_nettype none
// Keeps up to SLOTS sleepers (id plus absolute 64-bit deadline) and a system
// time. Add enters or re-arms a sleeper, remove drops one, tick advances the
// time by tick_increment and wakes every sleeper now due, one result word per
// wake in slot order with last on the final one (or one "nothing woken" word).
// Every add, remove or tick is accepted, then steps through each slot in turn
// via the single id/deadline comparator that scans the table, then commits
// and posts the final word; a stalled result port holds the scan or the
// commit. The unused command code is accepted and gives no result. The block
// is not ready while an item is in flight, but it takes the next command
// while the last result word still waits in the output register.
module sleep_deadline_timer_table #(
  parameter int SLOTS   = 16,
  parameter int ID_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [sdtt_pkg::INC_W-1:0]  cfg_wdata,
  sdtt_cmd_if.sink                         cmd,
  sdtt_res_if.source                       res
);
  import sdtt_pkg::*;

  localparam int IDX_W = SLOTS > 1 ? $clog2(SLOTS) : 1;

  logic [IDX_W-1:0]   rd_addr, wr_addr;
  store_ctl_t         ctl;
  logic [ID_BITS-1:0] wr_id, rd_id;
  logic [DL_W-1:0]    wr_deadline, rd_deadline;
  logic [SLOTS-1:0]   valid_vec;

  sdtt_scan_ctrl #(
    .SLOTS   (SLOTS),
    .ID_BITS (ID_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .cmd         (cmd),
    .res         (res),
    .rd_addr     (rd_addr),
    .wr_addr     (wr_addr),
    .ctl         (ctl),
    .wr_id       (wr_id),
    .wr_deadline (wr_deadline),
    .valid_vec   (valid_vec),
    .rd_id       (rd_id),
    .rd_deadline (rd_deadline)
  );

  sdtt_slot_store #(
    .SLOTS   (SLOTS),
    .ID_BITS (ID_BITS)
  ) u_store (
    .clk         (clk),
    .rst         (rst),
    .rd_addr     (rd_addr),
    .wr_addr     (wr_addr),
    .ctl         (ctl),
    .wr_id       (wr_id),
    .wr_deadline (wr_deadline),
    .valid_vec   (valid_vec),
    .rd_id       (rd_id),
    .rd_deadline (rd_deadline)
  );

  // Table updates happen only while a command is in flight.
  a_store_busy: assert property (@(posedge clk) disable iff (rst)
    (ctl.write || ctl.clear) |-> !cmd.ready)
    else $error("slot table updated while idle");

  // A real command holds off the next one: the block is not ready right after accepting it.
  a_cmd_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready && cmd.command != CMD_NONE) |=> !cmd.ready)
    else $error("command accepted back to back with a scan");

  // An empty tick ends the item with a zero id.
  a_none_woken: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.status == STAT_NONE_WOKEN) |-> (res.last && res.woken_id == '0))
    else $error("nothing-woken word malformed");

  // Write and clear never fire together.
  a_ctl_excl: assert property (@(posedge clk) disable iff (rst)
    !(ctl.write && ctl.clear))
    else $error("slot write and clear in the same cycle");

endmodule
`default_nettype wire

[bench/sleep_deadline_timer_table_test.sv]
// Self-checking bench for the sleep deadline timer table: directed and random commands.
`timescale 1ns / 1ps
module sleep_deadline_timer_table_test;
  import sdtt_pkg::*;

  localparam int SLOTS      = 16;
  localparam int POOL       = 20;
  localparam int HOLD_LEN   = 400;
  localparam int IDLE_LIMIT = 4000;
  localparam int PHASE_LEN  = 36;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_COMB} rx_mode_e;

  typedef struct {
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   woken_id;
    logic              last;
  } reply_t;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [INC_W-1:0] cfg_wdata;

  sdtt_cmd_if cmd_ch();
  sdtt_res_if res_ch();

  sleep_deadline_timer_table #(
    .SLOTS(SLOTS),
    .ID_BITS(16)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .cmd(cmd_ch),
    .res(res_ch)
  );

  // Shadow of the sleeper table.
  logic             slot_busy [SLOTS];
  logic [ID_W-1:0]  slot_owner[SLOTS];
  logic [DL_W-1:0]  slot_wake [SLOTS];
  logic [DL_W-1:0]  sys_time;
  logic [INC_W-1:0] tick_step;

  reply_t          reply_q[$];
  logic [ID_W-1:0] id_pool[POOL];
  int              mismatch_count;
  int              burst_left;
  bit              gaps_on;
  bit              hold_req;
  int              hold_left;
  int              mode_left;
  int              comb_cnt;
  rx_mode_e        rx_mode;
  int              idle_cycles;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Apply one accepted command word to the shadow table and queue its replies.
  function automatic void table_apply(logic [CMD_W-1:0] op, logic [ID_W-1:0] id,
                                      logic [DL_W-1:0] dl);
    int hit;
    int free_slot;
    int woke;
    hit = -1;
    free_slot = -1;
    woke = 0;
    for (int s = 0; s < SLOTS; s++) begin
      if (slot_busy[s] && slot_owner[s] == id && hit < 0) hit = s;
      if (!slot_busy[s] && free_slot < 0) free_slot = s;
    end
    case (op)
      CMD_ADD: begin
        if (hit < 0 && free_slot < 0) begin
          reply_q.push_back('{STAT_FULL, id, 1'b1});
        end else begin
          if (hit < 0) begin
            hit = free_slot;
            slot_busy[hit]  = 1'b1;
            slot_owner[hit] = id;
          end
          slot_wake[hit] = dl;
          reply_q.push_back('{STAT_OK, id, 1'b1});
        end
      end
      CMD_REMOVE: begin
        if (hit < 0) begin
          reply_q.push_back('{STAT_NOT_FOUND, id, 1'b1});
        end else begin
          slot_busy[hit] = 1'b0;
          reply_q.push_back('{STAT_OK, id, 1'b1});
        end
      end
      CMD_TICK: begin
        sys_time = sys_time + 64'(tick_step);
        for (int s = 0; s < SLOTS; s++) begin
          if (slot_busy[s] && slot_wake[s] <= sys_time) begin
            slot_busy[s] = 1'b0;
            reply_q.push_back('{STAT_WOKEN, slot_owner[s], 1'b0});
            woke++;
          end
        end
        if (woke == 0) reply_q.push_back('{STAT_NONE_WOKEN, '0, 1'b1});
        else reply_q[reply_q.size() - 1].last = 1'b1;
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (mismatch_count < 40)
      $display("mismatch: %s got %0h want %0h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // Offer one command word; drop valid for a random gap when a burst has ended.
  task automatic send_word(logic [CMD_W-1:0] op, logic [ID_W-1:0] id, logic [DL_W-1:0] dl);
    if (gaps_on && burst_left == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 8);
    end
    cmd_ch.valid      <= 1'b1;
    cmd_ch.command    <= op;
    cmd_ch.sleeper_id <= id;
    cmd_ch.deadline   <= dl;
    do @(posedge clk); while (!cmd_ch.ready);
    table_apply(op, id, dl);
    if (burst_left > 0) burst_left--;
  endtask

  // Drop valid, wait for every pending reply, then let the block go quiet.
  task automatic settle_table(int quiet_cycles);
    cmd_ch.valid <= 1'b0;
    burst_left = 0;
    while (reply_q.size() != 0) @(posedge clk);
    repeat (quiet_cycles) @(posedge clk);
  endtask

  task automatic write_increment(logic [INC_W-1:0] value);
    settle_table(SLOTS + 4);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    tick_step = value;
  endtask

  task automatic refill_pool();
    for (int i = 0; i < POOL; i++) id_pool[i] = 16'($urandom);
    id_pool[0] = '0;
    id_pool[1] = '1;
  endtask

  task automatic pick_item(output logic [CMD_W-1:0] op, output logic [ID_W-1:0] id,
                           output logic [DL_W-1:0] dl);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) op = CMD_ADD;
    else if (roll < 65) op = CMD_REMOVE;
    else if (roll < 95) op = CMD_TICK;
    else op = CMD_NONE;
    id = ($urandom_range(0, 9) == 0) ? 16'($urandom) : id_pool[$urandom_range(0, POOL - 1)];
    dl = {$urandom, $urandom};
    roll = $urandom_range(0, 9);
    // Most deadlines land a few ticks ahead so that wakes keep happening.
    if (roll < 7)
      dl = sys_time + 64'($urandom_range(0, 5)) * 64'(tick_step)
           + 64'($urandom_range(0, tick_step));
    else if (roll < 8)
      dl = sys_time - 64'($urandom);
  endtask

  task automatic test_basic_commands();
    send_word(CMD_TICK, 16'($urandom), {$urandom, $urandom});
    send_word(CMD_REMOVE, 16'h1234, 64'd0);
    send_word(CMD_ADD, 16'h0000, 64'd0);
    send_word(CMD_ADD, 16'hFFFF, '1);
    // Re-arm an id already present, due exactly at the next tick.
    send_word(CMD_ADD, 16'h0000, 64'd2000000);
    send_word(CMD_NONE, 16'($urandom), {$urandom, $urandom});
    send_word(CMD_TICK, 16'hFFFF, '1);
    send_word(CMD_REMOVE, 16'hFFFF, '1);
    settle_table(SLOTS + 4);
  endtask

  task automatic test_full_table();
    logic [ID_W-1:0] id;
    for (int i = 0; i < SLOTS; i++) begin
      id = 16'(i * 16'h1000 + 16'h0AB0 + i);
      send_word(CMD_ADD, id, sys_time + 64'($urandom_range(0, tick_step)));
    end
    send_word(CMD_ADD, 16'h0001, 64'd0);
    // Update of a present id still succeeds when the table is full.
    send_word(CMD_ADD, 16'h5AB5, sys_time + 64'(tick_step));
    send_word(CMD_TICK, 16'($urandom), {$urandom, $urandom});
    settle_table(SLOTS + 4);
  endtask

  task automatic test_output_backpressure();
    logic [CMD_W-1:0] op;
    logic [ID_W-1:0]  id;
    logic [DL_W-1:0]  dl;
    refill_pool();
    gaps_on  = 1'b0;
    hold_req = 1'b1;
    repeat (12) begin
      pick_item(op, id, dl);
      send_word(op, id, dl);
    end
    settle_table(SLOTS + 4);
    gaps_on = 1'b1;
  endtask

  task automatic test_increment_settings();
    logic [INC_W-1:0] steps[5];
    logic [CMD_W-1:0] op;
    logic [ID_W-1:0]  id;
    logic [DL_W-1:0]  dl;
    steps[0] = 32'd1;
    steps[1] = '1;
    steps[2] = 32'($urandom_range(2, 100));
    steps[3] = $urandom | 32'd1;
    steps[4] = TICK_INC_RESET;
    for (int p = 0; p < 5; p++) begin
      write_increment(steps[p]);
      refill_pool();
      gaps_on = (p % 2 == 0);
      repeat (PHASE_LEN) begin
        pick_item(op, id, dl);
        send_word(op, id, dl);
      end
      settle_table(SLOTS + 4);
      gaps_on = 1'b1;
    end
  endtask

  // Result side: stall patterns of its own, plus an optional long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (hold_req) begin
        hold_left = HOLD_LEN;
        hold_req  = 1'b0;
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(10, 120);
        rx_mode   = rx_mode_e'($urandom_range(0, 3));
      end
      mode_left--;
      comb_cnt++;
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN:   res_ch.ready <= 1'b1;
          RX_COIN:   res_ch.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: res_ch.ready <= ($urandom_range(0, 3) == 0);
          default:   res_ch.ready <= (comb_cnt % 5 != 4);
        endcase
      end
    end
  end

  // Compare each accepted result word with the oldest pending reply.
  always @(posedge clk) begin
    reply_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (reply_q.size() == 0) begin
        report_mismatch("word with nothing pending, status", 64'(res_ch.status), 64'd0);
      end else begin
        want = reply_q.pop_front();
        if (res_ch.status !== want.status)
          report_mismatch("status", 64'(res_ch.status), 64'(want.status));
        if (res_ch.woken_id !== want.woken_id)
          report_mismatch("woken_id", 64'(res_ch.woken_id), 64'(want.woken_id));
        if (res_ch.last !== want.last)
          report_mismatch("last", 64'(res_ch.last), 64'(want.last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_wdata         = TICK_INC_RESET;
    cmd_ch.valid      = 1'b0;
    cmd_ch.command    = CMD_NONE;
    cmd_ch.sleeper_id = '0;
    cmd_ch.deadline   = '0;
    res_ch.ready      = 1'b0;
    for (int s = 0; s < SLOTS; s++) begin
      slot_busy[s]  = 1'b0;
      slot_owner[s] = '0;
      slot_wake[s]  = '0;
    end
    sys_time       = '0;
    tick_step      = TICK_INC_RESET;
    mismatch_count = 0;
    burst_left     = 0;
    gaps_on        = 1'b1;
    hold_req       = 1'b0;
    hold_left      = 0;
    mode_left      = 0;
    comb_cnt       = 0;
    rx_mode        = RX_OPEN;
    idle_cycles    = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_basic_commands();
    test_full_table();
    test_output_backpressure();
    test_increment_settings();

    settle_table(40);
    if (mismatch_count == 0 && reply_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[sleep_deadline_timer_table.f]
hdl/sdtt_pkg.sv
hdl/sdtt_cmd_if.sv
hdl/sdtt_res_if.sv
hdl/sdtt_slot_store.sv
hdl/sdtt_scan_ctrl.sv
hdl/sleep_deadline_timer_table.sv
bench/sleep_deadline_timer_table_test.sv
